@@ rtl/md5sh_pkg.sv @@
// Shared types, constants and round tables of the MD5 stream hasher.
package md5sh_pkg;

  // Input request: one message byte and/or the end mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_req_t;

  // Output request: one digest byte
  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } out_req_t;

  // Four 32-bit MD5 words (chaining or working set)
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } abcd_t;

  localparam abcd_t MD5_INIT = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'h3f;
  localparam logic [5:0] LAST_ROUND = 6'h3f;
  localparam logic [3:0] LAST_DIGEST = 4'hf;

  // Per-round additive constant
  function automatic logic [31:0] md5_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left-rotate amount, indexed by {phase, round[1:0]}
  function automatic logic [4:0] md5_rot(input logic [3:0] idx);
    logic [4:0] s;
    unique case (idx)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/md5sh_block_buf.sv @@
// Sixteen-word message block buffer, written one byte lane at a time.
module md5sh_block_buf (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_pos_i,
  input  logic [7:0]  wr_byte_i,
  input  logic [3:0]  rd_idx_i,
  output logic [31:0] rd_word_o
);

  logic [15:0][3:0][7:0] words_q;

  // Write the byte into its little-endian lane
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      words_q[wr_pos_i[5:2]][wr_pos_i[1:0]] <= wr_byte_i;
    end
  end

  // Select the word the current round needs
  assign rd_word_o = words_q[rd_idx_i];

endmodule

@@ rtl/md5sh_round.sv @@
// Shared MD5 round unit: one of the 64 compression rounds per cycle.
module md5sh_round (
  input  md5sh_pkg::abcd_t work_i,
  input  logic [5:0]       round_i,
  input  logic [31:0]      msg_word_i,
  output logic [3:0]       msg_idx_o,
  output md5sh_pkg::abcd_t work_o
);

  import md5sh_pkg::*;

  logic [1:0]  phase;
  logic [3:0]  r4;
  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  shamt;
  logic [63:0] dbl;

  assign phase = round_i[5:4];
  assign r4    = round_i[3:0];

  // Pick the boolean function and message word for this phase
  always_comb begin
    unique case (phase)
      2'd0: begin
        f         = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
        msg_idx_o = r4;
      end
      2'd1: begin
        f         = (work_i.b & work_i.d) | (work_i.c & ~work_i.d);
        msg_idx_o = r4 * 4'd5 + 4'd1;
      end
      2'd2: begin
        f         = work_i.b ^ work_i.c ^ work_i.d;
        msg_idx_o = r4 * 4'd3 + 4'd5;
      end
      default: begin
        f         = work_i.c ^ (work_i.b | ~work_i.d);
        msg_idx_o = r4 * 4'd7;
      end
    endcase
  end

  // Add, rotate and shift the word set along
  assign sum   = work_i.a + f + md5_k(round_i) + msg_word_i;
  assign shamt = md5_rot({phase, round_i[1:0]});
  assign dbl   = {sum, sum} << shamt;

  assign work_o.a = work_i.d;
  assign work_o.b = work_i.b + dbl[63:32];
  assign work_o.c = work_i.b;
  assign work_o.d = work_i.c;

endmodule

@@ rtl/md5sh_ctrl.sv @@
// Sequencer of the MD5 hasher: byte intake, padding, compression and digest output.
module md5sh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  md5sh_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output md5sh_pkg::out_req_t out_req_o,
  output logic                wr_en_o,
  output logic [5:0]          wr_pos_o,
  output logic [7:0]          wr_byte_o,
  output logic [5:0]          round_o,
  output md5sh_pkg::abcd_t    work_o,
  input  md5sh_pkg::abcd_t    work_next_i
);

  import md5sh_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MARK  = 7'b0000010,
    ST_ZERO  = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_FOLD  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  state_e      resume_q, resume_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [5:0]  round_q, round_d;
  logic [3:0]  ocnt_q, ocnt_d;
  abcd_t       chain_q, chain_d;
  abcd_t       work_q, work_d;
  logic        in_acc;
  logic        blk_full;
  logic        start_cmp;
  logic [31:0] out_word;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign blk_full   = (fill_q == LAST_BYTE);
  assign wr_pos_o   = fill_q;
  assign round_o    = round_q;
  assign work_o     = work_q;

  // Sequence intake, padding, rounds and output
  always_comb begin
    state_d   = state_q;
    resume_d  = resume_q;
    fill_d    = fill_q;
    bits_d    = bits_q;
    round_d   = round_q;
    ocnt_d    = ocnt_q;
    chain_d   = chain_q;
    work_d    = work_q;
    wr_en_o   = 1'b0;
    wr_byte_o = '0;
    start_cmp = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_i.byte_valid) begin
            wr_en_o   = 1'b1;
            wr_byte_o = in_req_i.data_byte;
            fill_d    = fill_q + 6'd1;
            bits_d    = bits_q + 64'd8;
            if (blk_full) begin
              start_cmp = 1'b1;
              resume_d  = in_req_i.end_of_message ? ST_MARK : ST_IDLE;
            end else if (in_req_i.end_of_message) begin
              state_d = ST_MARK;
            end
          end else if (in_req_i.end_of_message) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        wr_en_o   = 1'b1;
        wr_byte_o = PAD_MARK;
        fill_d    = fill_q + 6'd1;
        if (blk_full) begin
          start_cmp = 1'b1;
          resume_d  = ST_ZERO;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (fill_q == LEN_OFFSET) begin
          state_d = ST_LEN;
        end else begin
          wr_en_o = 1'b1;
          fill_d  = fill_q + 6'd1;
          if (blk_full) begin
            start_cmp = 1'b1;
            resume_d  = ST_ZERO;
          end
        end
      end
      ST_LEN: begin
        wr_en_o   = 1'b1;
        wr_byte_o = bits_q[{fill_q[2:0], 3'b000} +: 8];
        fill_d    = fill_q + 6'd1;
        if (blk_full) begin
          start_cmp = 1'b1;
          resume_d  = ST_OUT;
        end
      end
      ST_ROUND: begin
        work_d  = work_next_i;
        round_d = round_q + 6'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        chain_d.a = chain_q.a + work_q.a;
        chain_d.b = chain_q.b + work_q.b;
        chain_d.c = chain_q.c + work_q.c;
        chain_d.d = chain_q.d + work_q.d;
        state_d   = resume_q;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          ocnt_d = ocnt_q + 4'd1;
          if (ocnt_q == LAST_DIGEST) begin
            chain_d = MD5_INIT;
            bits_d  = '0;
            fill_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Load the working set when a block is full
    if (start_cmp) begin
      state_d = ST_ROUND;
      work_d  = chain_q;
      round_d = '0;
    end
  end

  // Hold control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      resume_q <= ST_IDLE;
      fill_q   <= '0;
      bits_q   <= '0;
      round_q  <= '0;
      ocnt_q   <= '0;
      chain_q  <= MD5_INIT;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      fill_q   <= fill_d;
      bits_q   <= bits_d;
      round_q  <= round_d;
      ocnt_q   <= ocnt_d;
      chain_q  <= chain_d;
    end
  end

  // Working words carry no reset
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  // Drive the digest byte from the chaining words
  always_comb begin
    unique case (ocnt_q[3:2])
      2'd0:    out_word = chain_q.a;
      2'd1:    out_word = chain_q.b;
      2'd2:    out_word = chain_q.c;
      default: out_word = chain_q.d;
    endcase
  end

  assign out_valid_o           = (state_q == ST_OUT);
  assign out_req_o.digest_byte = out_word[{ocnt_q[1:0], 3'b000} +: 8];
  assign out_req_o.digest_last = (ocnt_q == LAST_DIGEST);

endmodule

@@ rtl/md5_stream_hasher_top.sv @@
// Top level of the MD5 stream hasher: sequencer, block buffer and round unit.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | input     | in_valid_i/in_stall_o  | in_req_i  (data_byte, byte_valid, end)
//   out     | output    | out_valid_o/out_stall_i| out_req_o (digest_byte, digest_last)
//
// The input takes one byte per cycle; every 64th byte starts a compression in the
// shared round unit (64 rounds, one per cycle, then a fold into the chaining words).
// The end request adds one pad or length byte per cycle (9 to 72 bytes, plus a turn
// to the length), one or two compressions, then the 16 digest bytes on the output.
// Reset restores the MD5 initial chaining words and clears the bit count and fill.
// The input stalls from a block's last byte until its compression ends, and from
// an end request until the final digest byte is taken; output stalls hold the byte.
module md5_stream_hasher_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  md5sh_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output md5sh_pkg::out_req_t out_req_o
);

  import md5sh_pkg::*;

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic [3:0]  msg_idx;
  logic [31:0] msg_word;
  logic [5:0]  round;
  abcd_t       work;
  abcd_t       work_next;

  md5sh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .wr_en_o     (wr_en),
    .wr_pos_o    (wr_pos),
    .wr_byte_o   (wr_byte),
    .round_o     (round),
    .work_o      (work),
    .work_next_i (work_next)
  );

  md5sh_block_buf u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_pos_i  (wr_pos),
    .wr_byte_i (wr_byte),
    .rd_idx_i  (msg_idx),
    .rd_word_o (msg_word)
  );

  md5sh_round u_round (
    .work_i     (work),
    .round_i    (round),
    .msg_word_i (msg_word),
    .msg_idx_o  (msg_idx),
    .work_o     (work_next)
  );

endmodule

@@ tb/sv/md5_stream_hasher_top_test.sv @@
// Self-checking testbench for md5_stream_hasher_top: random byte streams and digest checks.

class md5_digest_scoreboard;
  logic [31:0] round_add [64];
  int          rot_by [16];
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [63:0] bits_seen;
  logic [5:0]  fill;
  md5sh_pkg::out_req_t digest_q [$];
  int          errors;

  function new();
    round_add = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    rot_by = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    foreach (blk[i]) blk[i] = '0;
    errors = 0;
    clear_message();
  endfunction

  // Return chaining words, length and fill to their start values
  function void clear_message();
    chain[0] = md5sh_pkg::MD5_INIT.a;
    chain[1] = md5sh_pkg::MD5_INIT.b;
    chain[2] = md5sh_pkg::MD5_INIT.c;
    chain[3] = md5sh_pkg::MD5_INIT.d;
    bits_seen = '0;
    fill = '0;
  endfunction

  function logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Run the 64 rounds over the full block and fold into the chain
  function void compress();
    logic [31:0] a, b, c, d, f, t, sum;
    int g, ph;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 64; r++) begin
      ph = r >> 4;
      case (ph)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) & 15;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) & 15;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) & 15;
        end
      endcase
      t = d;
      sum = a + f + round_add[r] + blk[g];
      d = c;
      c = b;
      b = b + rotl(sum, rot_by[(ph << 2) | (r & 3)]);
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  // Pack one byte little-endian; compress when the block fills
  function void absorb(input logic [7:0] val);
    blk[fill[5:2]][8 * fill[1:0] +: 8] = val;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress();
  endfunction

  // Note an accepted input request and queue any digest it produces
  function void note_request(input md5sh_pkg::in_req_t r);
    logic [63:0] len;
    md5sh_pkg::out_req_t d;
    if (r.byte_valid) begin
      absorb(r.data_byte);
      bits_seen += 64'd8;
    end
    if (!r.end_of_message) return;
    len = bits_seen;
    absorb(md5sh_pkg::PAD_MARK);
    while (fill != md5sh_pkg::LEN_OFFSET) absorb(8'h00);
    for (int k = 0; k < 8; k++) absorb(len[8 * k +: 8]);
    for (int k = 0; k < 16; k++) begin
      d.digest_byte = chain[k >> 2][8 * (k & 3) +: 8];
      d.digest_last = (k == md5sh_pkg::LAST_DIGEST);
      digest_q.push_back(d);
    end
    clear_message();
  endfunction

  task report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Compare an accepted output request with the oldest expected digest byte
  task check_digest(input md5sh_pkg::out_req_t got);
    md5sh_pkg::out_req_t want;
    if (digest_q.size() == 0) begin
      report_mismatch($sformatf("digest byte %02h arrived with none expected",
                                got.digest_byte));
      return;
    end
    want = digest_q.pop_front();
    if (got.digest_byte !== want.digest_byte)
      report_mismatch($sformatf("digest_byte got %02h want %02h",
                                got.digest_byte, want.digest_byte));
    if (got.digest_last !== want.digest_last)
      report_mismatch($sformatf("digest_last got %b want %b",
                                got.digest_last, want.digest_last));
  endtask

  function int waiting();
    return digest_q.size();
  endfunction
endclass

module md5_stream_hasher_top_test;
  localparam int RANDOM_ITEMS = 210;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  md5sh_pkg::in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  md5sh_pkg::out_req_t out_req;

  int send_idle_pct = 25;
  int recv_stall_pct = 87;
  int items_sent = 0;
  md5_digest_scoreboard sb = new;

  md5_stream_hasher_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  always #1 clk = ~clk;

  // Hold the receiver off after reset so the first digest waits, then stall at random
  initial begin
    @(posedge rst_n);
    repeat (HOLD_CYCLES) @(posedge clk);
    forever begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      @(posedge clk);
    end
  end

  // Check every accepted output request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_digest(out_req);
  end

  // Offer one input request after a random gap and hold it until accepted
  task automatic send_request(input logic [7:0] data, input logic valid, input logic last);
    md5sh_pkg::in_req_t r;
    r.data_byte = data;
    r.byte_valid = valid;
    r.end_of_message = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    items_sent++;
  endtask

  // Send a message of len bytes with random ignored requests, ending on the last byte or with a bare end request
  task automatic send_message(input int len);
    logic tail;
    logic [7:0] val;
    tail = (len > 0) && ($urandom_range(1) == 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      if ($urandom_range(7) == 0) val = ($urandom_range(1) == 1) ? 8'hff : 8'h00;
      else val = 8'($urandom_range(255));
      send_request(val, 1'b1, tail && (k == len - 1));
    end
    if (!tail) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message twice in a row, with a junk data byte
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    // Ignored request between messages
    send_request(8'h5a, 1'b0, 1'b0);
    // "abc" with the end on the last byte
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // Extreme bytes, then a bare end request
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    // Single byte with end
    send_request(8'hff, 1'b1, 1'b1);
    // "abc" with an ignored request inside and a bare end
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'hc3, 1'b0, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b0);
    send_request(8'h3c, 1'b0, 1'b1);

    // Random messages: mostly short, some near the padding boundaries
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= 140) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (items_sent >= 70) begin
        send_idle_pct = 87;
        recv_stall_pct = 25;
      end
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          3: len = 64;
          default: len = 65;
        endcase
      end else begin
        len = $urandom_range(12);
      end
      send_message(len);
    end
    in_valid <= 1'b0;

    // Drain the outstanding digest bytes, then watch for strays
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
